>>> hdl/blpm_pkg.sv
// Shared types and constants for the binary trie longest prefix match block.
`timescale 1ns / 1ps

package blpm_pkg;

    localparam int KEY_BITS        = 32;
    localparam int DEF_NODE_COUNT  = 1024;
    localparam int LVL_W           = $clog2(KEY_BITS + 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_LOOKUP,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture the accepted item, start at the root
        logic step_ins;  // one insert level
        logic step_lkp;  // one lookup level
        logic emit;      // move the finished result into the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic done;      // the walk ends in this step
        logic out_free;  // output register can take a result this cycle
    } stat_t;

endpackage

>>> hdl/blpm_ctrl.sv
// Controller state machine: sequences accept, trie walk and result hand-off.
`timescale 1ns / 1ps

module blpm_ctrl
    import blpm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  in_op,
    output logic  in_ready,
    output cmd_t  cmd,
    input  stat_t stat
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_op == OP_LOOKUP) ? ST_LOOKUP : ST_INSERT;
                end
            end
            ST_INSERT, ST_LOOKUP:
            begin
                if (stat.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_INSERT:
            begin
                cmd.step_ins = 1'b1;
            end
            ST_LOOKUP:
            begin
                cmd.step_lkp = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> hdl/blpm_datapath.sv
// Datapath: node memories, root registers, walk registers and output register.
`timescale 1ns / 1ps

module blpm_datapath
    import blpm_pkg::*;
#(
    parameter int NODE_COUNT = DEF_NODE_COUNT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output stat_t               stat,
    input  logic [KEY_BITS-1:0] in_key,
    input  logic [KEY_BITS-1:0] in_mask,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                hit,
    output logic [KEY_BITS-1:0] match_net,
    output logic [KEY_BITS-1:0] match_mask,
    output logic                pool_full
);

    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam int NF_W  = $clog2(NODE_COUNT + 1);

    typedef logic [IDX_W-1:0] idx_t;

    // node memories; node zero lives in the root registers instead
    idx_t                c0_mem   [NODE_COUNT];
    idx_t                c1_mem   [NODE_COUNT];
    logic                term_mem [NODE_COUNT];
    logic [KEY_BITS-1:0] net_mem  [NODE_COUNT];
    logic [KEY_BITS-1:0] mask_mem [NODE_COUNT];

    idx_t                rd_c0_reg;
    idx_t                rd_c1_reg;
    logic                rd_term_reg;
    logic [KEY_BITS-1:0] rd_net_reg;
    logic [KEY_BITS-1:0] rd_mask_reg;

    idx_t                root_c0_reg;
    idx_t                root_c1_reg;
    logic                root_term_reg;
    logic [KEY_BITS-1:0] root_net_reg;
    logic [KEY_BITS-1:0] root_mask_reg;

    logic [KEY_BITS-1:0] key_reg,  key_next;
    logic [KEY_BITS-1:0] msk_reg,  msk_next;
    logic [KEY_BITS-1:0] path_reg, path_next;
    logic [KEY_BITS-1:0] rem_reg,  rem_next;
    idx_t                node_reg, node_next;
    logic                fresh_reg, fresh_next;
    logic [LVL_W-1:0]    lvl_reg,  lvl_next;
    logic [NF_W-1:0]     nf_reg,   nf_next;
    logic                found_reg, found_next;
    logic [KEY_BITS-1:0] best_net_reg,  best_net_next;
    logic [KEY_BITS-1:0] best_mask_reg, best_mask_next;

    logic                res_hit_reg,  res_hit_next;
    logic [KEY_BITS-1:0] res_net_reg,  res_net_next;
    logic [KEY_BITS-1:0] res_mask_reg, res_mask_next;
    logic                res_full_reg, res_full_next;

    logic                out_valid_reg;
    logic                out_hit_reg;
    logic [KEY_BITS-1:0] out_net_reg;
    logic [KEY_BITS-1:0] out_mask_reg;
    logic                out_full_reg;

    logic                is_root;
    logic                bit_sel;
    idx_t                cur_c0;
    idx_t                cur_c1;
    logic                cur_term;
    logic [KEY_BITS-1:0] cur_net;
    logic [KEY_BITS-1:0] cur_mask;
    idx_t                child;
    logic                child_nz;
    logic                pool_out;
    logic                ins_done;
    logic                lkp_done;
    idx_t                nf_idx;

    logic                wr_c0_en,  wr_c1_en, wr_term_en, wr_nm_en;
    idx_t                wr_c0_data, wr_c1_data;
    logic                wr_term_data;

    // current node view: a fresh node has no children yet
    assign is_root  = (node_reg == '0);
    assign bit_sel  = path_reg[KEY_BITS-1];
    assign cur_c0   = fresh_reg ? '0 : (is_root ? root_c0_reg : rd_c0_reg);
    assign cur_c1   = fresh_reg ? '0 : (is_root ? root_c1_reg : rd_c1_reg);
    assign cur_term = is_root ? root_term_reg : rd_term_reg;
    assign cur_net  = is_root ? root_net_reg  : rd_net_reg;
    assign cur_mask = is_root ? root_mask_reg : rd_mask_reg;
    assign child    = bit_sel ? cur_c1 : cur_c0;
    assign child_nz = (child != '0);
    assign pool_out = (nf_reg == NF_W'(NODE_COUNT));
    assign nf_idx   = nf_reg[IDX_W-1:0];
    assign ins_done = (rem_reg == '0) || (!child_nz && pool_out);
    assign lkp_done = (lvl_reg == LVL_W'(KEY_BITS)) || !child_nz;

    assign stat.done     = cmd.step_ins ? ins_done : lkp_done;
    assign stat.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        key_next       = key_reg;
        msk_next       = msk_reg;
        path_next      = path_reg;
        rem_next       = rem_reg;
        node_next      = node_reg;
        fresh_next     = fresh_reg;
        lvl_next       = lvl_reg;
        nf_next        = nf_reg;
        found_next     = found_reg;
        best_net_next  = best_net_reg;
        best_mask_next = best_mask_reg;
        res_hit_next   = res_hit_reg;
        res_net_next   = res_net_reg;
        res_mask_next  = res_mask_reg;
        res_full_next  = res_full_reg;
        wr_c0_en       = 1'b0;
        wr_c1_en       = 1'b0;
        wr_term_en     = 1'b0;
        wr_nm_en       = 1'b0;
        wr_c0_data     = '0;
        wr_c1_data     = '0;
        wr_term_data   = 1'b0;

        if (cmd.load)
        begin
            key_next   = in_key;
            msk_next   = in_mask;
            path_next  = in_key;
            rem_next   = in_mask;
            node_next  = '0;
            fresh_next = 1'b0;
            lvl_next   = '0;
            found_next = 1'b0;
        end
        else if (cmd.step_ins)
        begin
            if (rem_reg == '0)
            begin
                // end of the prefix: mark terminal, finish a fresh leaf
                wr_term_en    = 1'b1;
                wr_term_data  = 1'b1;
                wr_nm_en      = 1'b1;
                wr_c0_en      = fresh_reg;
                wr_c1_en      = fresh_reg;
                res_hit_next  = 1'b1;
                res_net_next  = key_reg;
                res_mask_next = msk_reg;
                res_full_next = 1'b0;
            end
            else if (child_nz)
            begin
                node_next = child;
                path_next = {path_reg[KEY_BITS-2:0], 1'b0};
                rem_next  = {rem_reg[KEY_BITS-2:0], 1'b0};
            end
            else if (pool_out)
            begin
                // out of nodes: still leave a fresh node fully formed
                wr_c0_en      = fresh_reg;
                wr_c1_en      = fresh_reg;
                wr_term_en    = fresh_reg;
                res_hit_next  = 1'b0;
                res_net_next  = '0;
                res_mask_next = '0;
                res_full_next = 1'b1;
            end
            else
            begin
                if (fresh_reg)
                begin
                    wr_c0_en   = 1'b1;
                    wr_c1_en   = 1'b1;
                    wr_term_en = 1'b1;
                    wr_c0_data = bit_sel ? '0 : nf_idx;
                    wr_c1_data = bit_sel ? nf_idx : '0;
                end
                else
                begin
                    wr_c0_en   = !bit_sel;
                    wr_c1_en   = bit_sel;
                    wr_c0_data = nf_idx;
                    wr_c1_data = nf_idx;
                end
                node_next  = nf_idx;
                fresh_next = 1'b1;
                nf_next    = nf_reg + NF_W'(1);
                path_next  = {path_reg[KEY_BITS-2:0], 1'b0};
                rem_next   = {rem_reg[KEY_BITS-2:0], 1'b0};
            end
        end
        else if (cmd.step_lkp)
        begin
            if (cur_term)
            begin
                found_next     = 1'b1;
                best_net_next  = cur_net;
                best_mask_next = cur_mask;
            end
            if (lkp_done)
            begin
                res_hit_next  = found_reg || cur_term;
                res_net_next  = cur_term ? cur_net  : (found_reg ? best_net_reg  : '0);
                res_mask_next = cur_term ? cur_mask : (found_reg ? best_mask_reg : '0);
                res_full_next = 1'b0;
            end
            else
            begin
                node_next = child;
                path_next = {path_reg[KEY_BITS-2:0], 1'b0};
                lvl_next  = lvl_reg + LVL_W'(1);
            end
        end
    end

    // node memories: one write port at the current node, registered read at the next
    always_ff @(posedge clk)
    begin
        if (wr_c0_en && !is_root)
        begin
            c0_mem[node_reg] <= wr_c0_data;
        end
        if (wr_c1_en && !is_root)
        begin
            c1_mem[node_reg] <= wr_c1_data;
        end
        if (wr_term_en && !is_root)
        begin
            term_mem[node_reg] <= wr_term_data;
        end
        if (wr_nm_en && !is_root)
        begin
            net_mem[node_reg]  <= key_reg;
            mask_mem[node_reg] <= msk_reg;
        end
        rd_c0_reg   <= c0_mem[node_next];
        rd_c1_reg   <= c1_mem[node_next];
        rd_term_reg <= term_mem[node_next];
        rd_net_reg  <= net_mem[node_next];
        rd_mask_reg <= mask_mem[node_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_c0_reg   <= '0;
            root_c1_reg   <= '0;
            root_term_reg <= 1'b0;
            nf_reg        <= NF_W'(1);
            node_reg      <= '0;
            fresh_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_c0_en && is_root)
            begin
                root_c0_reg <= wr_c0_data;
            end
            if (wr_c1_en && is_root)
            begin
                root_c1_reg <= wr_c1_data;
            end
            if (wr_term_en && is_root)
            begin
                root_term_reg <= wr_term_data;
            end
            nf_reg    <= nf_next;
            node_reg  <= node_next;
            fresh_reg <= fresh_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_nm_en && is_root)
        begin
            root_net_reg  <= key_reg;
            root_mask_reg <= msk_reg;
        end
        key_reg       <= key_next;
        msk_reg       <= msk_next;
        path_reg      <= path_next;
        rem_reg       <= rem_next;
        lvl_reg       <= lvl_next;
        found_reg     <= found_next;
        best_net_reg  <= best_net_next;
        best_mask_reg <= best_mask_next;
        res_hit_reg   <= res_hit_next;
        res_net_reg   <= res_net_next;
        res_mask_reg  <= res_mask_next;
        res_full_reg  <= res_full_next;
        if (cmd.emit)
        begin
            out_hit_reg  <= res_hit_reg;
            out_net_reg  <= res_net_reg;
            out_mask_reg <= res_mask_reg;
            out_full_reg <= res_full_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = out_hit_reg;
    assign match_net  = out_net_reg;
    assign match_mask = out_mask_reg;
    assign pool_full  = out_full_reg;

    a_nf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nf_reg <= NF_W'(NODE_COUNT))
        else $error("free pointer past the end of the node pool");

    a_nf_grow: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (nf_reg == $past(nf_reg) || nf_reg == $past(nf_reg) + NF_W'(1)))
        else $error("free pointer moved by other than one node");

    a_fresh_not_root: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg |-> !is_root)
        else $error("root marked as newly allocated");

    a_hit_xor_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_hit_reg && out_full_reg))
        else $error("result reports both a hit and an exhausted pool");

endmodule

>>> hdl/binary_trie_longest_prefix_match_top.sv
// Top level of the binary trie longest prefix match routing table.
`timescale 1ns / 1ps

// Routing table kept as a one-bit-per-level binary trie in a pool of NODE_COUNT
// nodes (node zero is the root). tuser = 0 inserts key/prefix_mask: the walk
// takes one level per mask bit down to the mask's last set bit, allocating
// nodes as needed, and returns hit=1 with the stored net and mask, or
// pool_full=1 if the pool runs out (nodes already made stay). tuser = 1 looks
// up key and returns the deepest terminal node on its path, or hit=0 with zero
// net and mask. One item is handled at a time: the node memories are read once
// per trie level through a registered read port, and after the last level comes
// one final step, then the output register is loaded once it is free.
// A finished result sits in an output register, so the next item is accepted
// while it waits to be taken. No clearing pass is needed after reset: only the
// root is cleared, and an allocated node has its child links and terminal flag
// written before they are ever read (net and mask when it is made terminal).
module binary_trie_longest_prefix_match_top
    import blpm_pkg::*;
#(
    parameter int NODE_COUNT = DEF_NODE_COUNT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [2*KEY_BITS-1:0] s_axis_tdata,   // key, prefix_mask
    input  logic                  s_axis_tuser,   // op
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [2*KEY_BITS-1:0] m_axis_tdata,   // match_net, match_mask
    output logic [1:0]            m_axis_tuser    // hit, pool_full
);

    cmd_t  cmd;
    stat_t stat;

    logic                hit;
    logic                pool_full;
    logic [KEY_BITS-1:0] match_net;
    logic [KEY_BITS-1:0] match_mask;

    blpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    blpm_datapath #(
        .NODE_COUNT (NODE_COUNT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_key     (s_axis_tdata[KEY_BITS-1:0]),
        .in_mask    (s_axis_tdata[2*KEY_BITS-1:KEY_BITS]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .hit        (hit),
        .match_net  (match_net),
        .match_mask (match_mask),
        .pool_full  (pool_full)
    );

    // result transfer: net in the low word, mask in the high word
    assign m_axis_tdata = {match_mask, match_net};
    assign m_axis_tuser = {pool_full, hit};

endmodule
